/* rtl/synva_pkg.sv */
package synva_pkg;

    localparam int VOICES = 64;
    localparam int RANK_W = 16;
    localparam int IDX_W  = $clog2(VOICES);
    localparam int CNT_W  = $clog2(VOICES + 1);
    localparam int KEY_W  = 7;
    localparam int TIME_W = 32;
    localparam int ACT_W  = 2;

    localparam int IN_TDATA_W  = ((KEY_W + 2 * TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * IDX_W + CNT_W + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd2;

    localparam logic [1:0] TONE_FREE      = 2'd0;
    localparam logic [1:0] TONE_SOUNDING  = 2'd1;
    localparam logic [1:0] TONE_RELEASING = 2'd2;

    localparam logic NOISE_FREE     = 1'b0;
    localparam logic NOISE_SOUNDING = 1'b1;

    localparam logic [RANK_W-1:0] RANK_NEW = RANK_W'(VOICES);

    typedef struct packed {
        logic [1:0]        tone_status;
        logic [RANK_W-1:0] tone_rank;
        logic [KEY_W-1:0]  tone_key;
        logic [TIME_W-1:0] tone_start;
        logic [TIME_W-1:0] tone_life;
        logic              noise_status;
        logic [RANK_W-1:0] noise_rank;
        logic [TIME_W-1:0] noise_start;
    } voice_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lifetime;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] tone_voice;
        logic             tone_changed;
        logic [IDX_W-1:0] noise_voice;
        logic             noise_started;
        logic [CNT_W-1:0] active_count;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } wr_ctl_t;

endpackage

/* rtl/synva_mem.sv */
module synva_mem
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [synva_pkg::IDX_W-1:0] rd_addr,
    output synva_pkg::voice_t          rd_data,
    input  synva_pkg::wr_ctl_t         wr_ctl,
    input  synva_pkg::voice_t          wr_data
);
    import synva_pkg::*;

    voice_t              voice_mem [VOICES];
    voice_t              rd_data_reg;
    logic                rd_valid_reg;
    logic [VOICES-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.en)
        begin
            voice_mem[wr_ctl.addr] <= wr_data;
        end
        rd_data_reg <= voice_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ctl.en)
            begin
                valid_reg[wr_ctl.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // entries never written read as free voices at rank zero
    always_comb
    begin
        rd_data = rd_data_reg;
        if (!rd_valid_reg)
        begin
            rd_data.tone_status  = TONE_FREE;
            rd_data.tone_rank    = '0;
            rd_data.tone_key     = '0;
            rd_data.noise_status = NOISE_FREE;
            rd_data.noise_rank   = '0;
        end
    end

endmodule

/* rtl/synva_ctrl.sv */
module synva_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  synva_pkg::cmd_t             in_cmd,
    input  logic [synva_pkg::TIME_W-1:0] noise_life,
    output logic [synva_pkg::IDX_W-1:0] rd_addr,
    input  synva_pkg::voice_t           rd_data,
    output synva_pkg::wr_ctl_t          wr_ctl,
    output synva_pkg::voice_t           wr_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output synva_pkg::res_t             res
);
    import synva_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MODIFY,
        S_DONE
    } state_t;

    localparam logic [IDX_W:0] LAST_CNT = (IDX_W + 1)'(VOICES);

    state_t             state_reg,  state_next;
    logic [IDX_W:0]     cnt_reg,    cnt_next;
    cmd_t               cmd_reg,    cmd_next;
    logic [RANK_W-1:0]  tmin_reg,   tmin_next;
    logic [IDX_W-1:0]   tidx_reg,   tidx_next;
    logic [RANK_W-1:0]  nmin_reg,   nmin_next;
    logic [IDX_W-1:0]   nidx_reg,   nidx_next;
    logic               found_reg,  found_next;
    logic [IDX_W-1:0]   midx_reg,   midx_next;
    logic [CNT_W-1:0]   active_reg, active_next;
    res_t               res_reg,    res_next;

    logic [IDX_W:0]     cnt_m1;
    logic [IDX_W-1:0]   data_idx;
    logic               have_data;
    logic [TIME_W-1:0]  tone_age;
    logic [TIME_W-1:0]  noise_age;
    logic               is_on;
    logic               is_off;
    voice_t             w;

    assign cnt_m1    = cnt_reg - 1'b1;
    assign data_idx  = cnt_m1[IDX_W-1:0];
    assign have_data = (cnt_reg != '0);
    assign tone_age  = cmd_reg.now - rd_data.tone_start;
    assign noise_age = cmd_reg.now - rd_data.noise_start;
    assign is_on     = (cmd_reg.action == ACT_NOTE_ON);
    assign is_off    = (cmd_reg.action == ACT_NOTE_OFF);

    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;
    assign wr_data   = w;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        tmin_next   = tmin_reg;
        tidx_next   = tidx_reg;
        nmin_next   = nmin_reg;
        nidx_next   = nidx_reg;
        found_next  = found_reg;
        midx_next   = midx_reg;
        active_next = active_reg;
        res_next    = res_reg;
        wr_ctl.en   = 1'b0;
        wr_ctl.addr = data_idx;

        // modified copy of the entry arriving from memory
        w = rd_data;
        case (cmd_reg.action)
            ACT_NOTE_ON:
            begin
                if (data_idx == tidx_reg)
                begin
                    w.tone_status = TONE_SOUNDING;
                    w.tone_rank   = RANK_NEW;
                    w.tone_key    = cmd_reg.key;
                    w.tone_start  = cmd_reg.now;
                    w.tone_life   = cmd_reg.lifetime;
                end
                if (data_idx == nidx_reg)
                begin
                    w.noise_status = NOISE_SOUNDING;
                    w.noise_rank   = RANK_NEW;
                    w.noise_start  = cmd_reg.now;
                end
                if (w.tone_rank != '0)
                begin
                    w.tone_rank = w.tone_rank - 1'b1;
                end
                if (w.noise_rank != '0)
                begin
                    w.noise_rank = w.noise_rank - 1'b1;
                end
            end
            ACT_NOTE_OFF:
            begin
                if (found_reg && data_idx == midx_reg)
                begin
                    w.tone_status = TONE_RELEASING;
                    w.tone_rank   = RANK_NEW;
                    w.tone_start  = cmd_reg.now;
                    w.tone_life   = rd_data.tone_life >> 4;
                end
                if (data_idx == nidx_reg)
                begin
                    w.noise_status = NOISE_SOUNDING;
                    w.noise_rank   = RANK_NEW;
                    w.noise_start  = cmd_reg.now;
                end
            end
            ACT_TICK:
            begin
                if ((rd_data.tone_status == TONE_SOUNDING ||
                     rd_data.tone_status == TONE_RELEASING) &&
                    tone_age >= rd_data.tone_life)
                begin
                    w.tone_status = TONE_FREE;
                end
                if (rd_data.noise_status == NOISE_SOUNDING && noise_age >= noise_life)
                begin
                    w.noise_status = NOISE_FREE;
                end
            end
            default:
            begin
                w = rd_data;
            end
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = in_cmd;
                    cnt_next    = '0;
                    tmin_next   = RANK_NEW;
                    tidx_next   = '0;
                    nmin_next   = RANK_NEW;
                    nidx_next   = '0;
                    found_next  = 1'b0;
                    midx_next   = '0;
                    active_next = '0;
                    if (in_cmd.action == ACT_NOTE_ON || in_cmd.action == ACT_NOTE_OFF)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_MODIFY;
                    end
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (have_data)
                begin
                    if (rd_data.tone_rank < tmin_reg)
                    begin
                        tmin_next = rd_data.tone_rank;
                        tidx_next = data_idx;
                    end
                    if (rd_data.noise_rank < nmin_reg)
                    begin
                        nmin_next = rd_data.noise_rank;
                        nidx_next = data_idx;
                    end
                    if (!found_reg && rd_data.tone_status == TONE_SOUNDING &&
                        rd_data.tone_key == cmd_reg.key)
                    begin
                        found_next = 1'b1;
                        midx_next  = data_idx;
                    end
                end
                if (cnt_reg == LAST_CNT)
                begin
                    cnt_next   = '0;
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (have_data)
                begin
                    wr_ctl.en   = 1'b1;
                    active_next = active_reg + CNT_W'(w.tone_status != TONE_FREE);
                end
                if (cnt_reg == LAST_CNT)
                begin
                    cnt_next               = '0;
                    state_next             = S_DONE;
                    res_next.tone_changed  = is_on || (is_off && found_reg);
                    res_next.tone_voice    = is_on ? tidx_reg :
                                             ((is_off && found_reg) ? midx_reg : '0);
                    res_next.noise_started = is_on || is_off;
                    res_next.noise_voice   = (is_on || is_off) ? nidx_reg : '0;
                    res_next.active_count  = active_next;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            cmd_reg    <= '0;
            tmin_reg   <= '0;
            tidx_reg   <= '0;
            nmin_reg   <= '0;
            nidx_reg   <= '0;
            found_reg  <= 1'b0;
            midx_reg   <= '0;
            active_reg <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cmd_reg    <= cmd_next;
            tmin_reg   <= tmin_next;
            tidx_reg   <= tidx_next;
            nmin_reg   <= nmin_next;
            nidx_reg   <= nidx_next;
            found_reg  <= found_next;
            midx_reg   <= midx_next;
            active_reg <= active_next;
            res_reg    <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN || state_reg == S_MODIFY) && cnt_reg != LAST_CNT)
        |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("scan counter did not advance");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= CNT_W'(VOICES))
        else $error("active count above voice count");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SCAN || state_reg == S_MODIFY))
        else $error("accepted beat did not start a pass");

    a_write_in_modify: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ctl.en |-> (state_reg == S_MODIFY && cnt_reg != '0))
        else $error("memory write outside modify pass");
`endif

endmodule

/* rtl/synth_voice_allocator_unit.sv */
// Note-on and note-off: a read pass and a read-modify-write pass over the
// voice memory between the accepted beat and the result.
// Tick and unused actions: the write pass only.
// One item at a time; the next beat is taken in the cycle after the result
// leaves the sequencer, even while the output register still holds it.
// Reset: all voices free at rank zero, noise_lifetime 4800, no memory sweep.
module synth_voice_allocator_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // key, now, lifetime
    input  logic [synva_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [synva_pkg::ACT_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tone_voice, noise_voice, active_count
    output logic [synva_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tone_changed, noise_started
    output logic [1:0]                        m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [synva_pkg::TIME_W-1:0]      cfg_data
);
    import synva_pkg::*;

    cmd_t               in_cmd;
    logic [TIME_W-1:0]  noise_life_reg;
    logic [IDX_W-1:0]   rd_addr;
    voice_t             rd_data;
    wr_ctl_t            wr_ctl;
    voice_t             wr_data;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               out_valid_reg;
    res_t               out_reg;

    assign in_cmd.action   = s_axis_tuser;
    assign in_cmd.key      = s_axis_tdata[KEY_W-1:0];
    assign in_cmd.now      = s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
    assign in_cmd.lifetime = s_axis_tdata[KEY_W+2*TIME_W-1:KEY_W+TIME_W];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_life_reg <= TIME_W'(4800);
        end
        else if (cfg_valid)
        begin
            noise_life_reg <= cfg_data;
        end
    end

    synva_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_ctl  (wr_ctl),
        .wr_data (wr_data)
    );

    synva_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (in_cmd),
        .noise_life (noise_life_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_ctl     (wr_ctl),
        .wr_data    (wr_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // load the output beat whenever the register is empty or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_reg.active_count, out_reg.noise_voice,
                                          out_reg.tone_voice});
    assign m_axis_tuser  = {out_reg.noise_started, out_reg.tone_changed};

endmodule
